/* hdl/wwmc_pkg.sv */
// Shared types, register indexes and the delimiter classifier of the word match counter.
package wwmc_pkg;

	localparam int TEXT_W   = 8;
	localparam int TARGET_W = 64;
	localparam int TLEN_W   = 4;
	localparam int COUNT_W  = 32;
	localparam int INDEX_W  = 1;

	localparam logic [INDEX_W-1:0] REG_TARGET_WORD   = 1'd0;
	localparam logic [INDEX_W-1:0] REG_TARGET_LENGTH = 1'd1;

	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

	typedef struct packed {
		logic              fire;
		logic [TEXT_W-1:0] text;
		logic              last;
	} tok_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_next;
		logic               idle;
	} tok_stat_t;

	function automatic logic is_delim(input logic [TEXT_W-1:0] b);
		logic d;
		case (b) inside
			8'h20, 8'h60, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25,
			8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h3D, 8'h5F,
			8'h2B, 8'h7C, 8'h2C, 8'h2E, 8'h2F, 8'h3C, 8'h3E, 8'h3F,
			8'h27, 8'h22, 8'h5C, 8'h0A, 8'h09, 8'h08: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

/* hdl/wwmc_token_tracker.sv */
// Token position, mismatch flag and saturating match counter.
module wwmc_token_tracker
	import wwmc_pkg::*;
#(
	parameter int MAX_WORD_LEN = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tok_in_t             tok_in,
	input  logic [TARGET_W-1:0] target_word,
	input  logic [TLEN_W-1:0]   target_length,
	output tok_stat_t           tok_stat
);

	localparam int PW   = $clog2(MAX_WORD_LEN + 2);
	localparam int IDXW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int CW   = (PW > TLEN_W) ? PW : TLEN_W;

	logic [PW-1:0]      pos_q;
	logic               mism_q;
	logic [COUNT_W-1:0] count_q;

	logic [TEXT_W-1:0]  word_bytes [MAX_WORD_LEN];
	logic               delim;
	logic               pos_in_word;
	logic [TEXT_W-1:0]  want;
	logic               mism_grow;
	logic [PW-1:0]      pos_grow;
	logic               do_close;
	logic [PW-1:0]      close_pos;
	logic               close_mism;
	logic               len_ok;
	logic               hit;
	logic [PW-1:0]      pos_d;
	logic               mism_d;
	logic [COUNT_W-1:0] count_d;

	always_comb begin
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			word_bytes[i] = target_word[TEXT_W*i +: TEXT_W];
		end
	end

	always_comb begin
		delim       = is_delim(tok_in.text);
		pos_in_word = (CW'(pos_q) < CW'(target_length)) && (pos_q < PW'(MAX_WORD_LEN));
		want        = pos_in_word ? word_bytes[pos_q[IDXW-1:0]] : '0;
		mism_grow   = mism_q || !pos_in_word || (want != tok_in.text);
		pos_grow    = (pos_q < PW'(MAX_WORD_LEN + 1)) ? PW'(pos_q + 1'b1) : pos_q;
		do_close    = delim || tok_in.last;
		close_pos   = delim ? pos_q : pos_grow;
		close_mism  = delim ? mism_q : mism_grow;
		len_ok      = (target_length != '0) && (CW'(target_length) <= CW'(MAX_WORD_LEN));
		hit         = do_close && (close_pos != '0) && !close_mism && len_ok &&
			(CW'(close_pos) == CW'(target_length));
		pos_d       = do_close ? '0 : pos_grow;
		mism_d      = do_close ? 1'b0 : mism_grow;
		count_d     = (hit && (count_q != COUNT_TOP)) ? COUNT_W'(count_q + 1'b1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mism_q  <= 1'b0;
			count_q <= '0;
		end else if (tok_in.fire) begin
			pos_q   <= pos_d;
			mism_q  <= mism_d;
			count_q <= count_d;
		end
	end

	assign tok_stat.count_next = count_d;
	assign tok_stat.idle       = (pos_q == '0) && !mism_q;

endmodule

/* hdl/whole_word_match_counter.sv */
// Top level of the whole-word match counter: registers, handshakes and checks.
// Usage:
//   Send text one byte per word on the input channel (text_byte, end_of_text,
//   in_valid/in_ready). Mark the final byte with end_of_text.
//   Each input word yields one output word (match_count, count_final,
//   out_valid/out_ready): the saturating count of tokens equal to the target,
//   including a token that ends at that byte.
//   Tokens end at space, tab, LF, BS and most punctuation; runs count as one.
//   Program target_word (index 0) and target_length (index 1, 1..8) through
//   write_enable/reg_index/write_data while no word is in flight.
// Timing:
//   An accepted word is held in the input register, then the token update
//   feeds the result register that drives out_valid.
//   Throughput is one word per cycle while the output is not stalled; the
//   token update is a single byte compare plus a 32-bit increment.
// Reset and stall:
//   Reset clears both stages, the token state and the count, and loads
//   target_word = 0, target_length = 1. A stalled output holds its word;
//   in_ready drops only once both stages are full.
module whole_word_match_counter
	import wwmc_pkg::*;
#(
	parameter int MAX_WORD_LEN = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TEXT_W-1:0]   text_byte,
	input  logic                end_of_text,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COUNT_W-1:0]  match_count,
	output logic                count_final,
	input  logic                write_enable,
	input  logic [INDEX_W-1:0]  reg_index,
	input  logic [TARGET_W-1:0] write_data
);

	logic [TARGET_W-1:0] target_word_q;
	logic [TLEN_W-1:0]   target_length_q;

	logic                valid_s1;
	logic [TEXT_W-1:0]   text_s1;
	logic                last_s1;
	logic                valid_s2;
	logic [COUNT_W-1:0]  count_s2;
	logic                final_s2;

	logic                take_s2;
	logic                advance_s1;
	tok_in_t             tok_in;
	tok_stat_t           tok_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_word_q   <= '0;
			target_length_q <= TLEN_W'(1);
		end else if (write_enable) begin
			case (reg_index)
				REG_TARGET_WORD:   target_word_q   <= write_data;
				REG_TARGET_LENGTH: target_length_q <= write_data[TLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign take_s2    = !valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && take_s2;
	assign in_ready   = !valid_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			text_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	assign tok_in.fire = advance_s1;
	assign tok_in.text = text_s1;
	assign tok_in.last = last_s1;

	wwmc_token_tracker #(
		.MAX_WORD_LEN(MAX_WORD_LEN)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_in       (tok_in),
		.target_word  (target_word_q),
		.target_length(target_length_q),
		.tok_stat     (tok_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			count_s2 <= tok_stat.count_next;
			final_s2 <= last_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign match_count = count_s2;
	assign count_final = final_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && valid_s2 && out_ready) |=> (count_s2 >= $past(count_s2)))
		else $error("match count decreased");

	a_final_clears_token: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && final_s2) |-> tok_stat.idle)
		else $error("token state not cleared after final byte");

	a_stall_blocks_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while both stages are full");

endmodule
